// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define UEA_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define UEA_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/uea_pkg.sv -----
// ----------------------------------------------------------------------------
// uea_pkg
// Types and constants of the ultrasonic echo averager.
// ----------------------------------------------------------------------------
package uea_pkg;

   // field widths
   localparam int ECHO_W  = 16;
   localparam int DIST_W  = 21;
   localparam int CFG_W   = 21;
   localparam int COUNT_W = 20;
   localparam int SUM_W   = 26;
   localparam int FRAC_W  = 8;

   // serial divider geometry: (lin << 8) is the widest dividend
   localparam int DIV_N_W   = DIST_W + FRAC_W;
   localparam int DIV_D_W   = CFG_W;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // echo time to 0.01 mm: (avg * 17415) >> 10
   localparam int SCALE_W     = 15;
   localparam int PROD_W      = ECHO_W + SCALE_W;
   localparam logic [SCALE_W-1:0] SCALE_MUL = 15'd17415;
   localparam int SCALE_SHIFT = 10;

   // range ladder bounds and offsets
   localparam logic [DIST_W-1:0] RANGE_1 = 21'd10000;
   localparam logic [DIST_W-1:0] RANGE_2 = 21'd20000;
   localparam logic [DIST_W-1:0] RANGE_3 = 21'd30000;
   localparam logic [DIST_W-1:0] RANGE_4 = 21'd40000;
   localparam logic [DIST_W-1:0] RANGE_5 = 21'd50000;
   localparam logic [DIST_W-1:0] RANGE_6 = 21'd60000;
   localparam logic [DIST_W-1:0] OFS_SUB_2 = 21'd91;
   localparam logic [DIST_W-1:0] OFS_SUB_3 = 21'd99;
   localparam logic [DIST_W-1:0] OFS_SUB_4 = 21'd116;
   localparam logic [DIST_W-1:0] OFS_ADD_5 = 21'd90;
   localparam logic [DIST_W-1:0] OFS_ADD_6 = 21'd1970;
   localparam logic [DIST_W-1:0] OFS_ADD_7 = 21'd1610;

   // register map
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_REFERENCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THICKNESS = 2'd1;
   localparam logic [CFG_W-1:0] THICKNESS_RESET = 21'd1000;

   // sequencer states
   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_AVERAGE,
      ST_SCALE,
      ST_COUNT,
      ST_HOLD
   } state_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/core/ultrasonic_echo_average_calibrate.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_echo_average_calibrate
// Averages blocks of SAMPLES echo times, converts to calibrated distance,
// linear measure against a reference and a Q8 plate count.
//
//   channel  direction  payload (low bit first)
//   req      in         echo_time[15:0]
//   rsp      out        calibrated_distance[20:0], linear_measure[20:0],
//                       plate_count[19:0], two zero bits
//   csr      in         index 0 reference_distance, 1 plate_thickness
//
// While the sequencer accumulates, req_tready is high and an item that does
// not close a block is taken at once. The item closing a block keeps
// req_tready low through the serial divide by SAMPLES, three scale/calibrate
// stages, the launch and serial divide by the plate thickness, the hold state
// and the output register load; both divides use the shared bit-serial divider.
// Synchronous reset clears the sum, count, sequencer and output valid, zeroes
// the reference and sets the thickness to THICKNESS_RESET; no clearing pass.
// A result waiting in the output register stalls only the next block's end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ultrasonic_echo_average_calibrate #(
   parameter int SAMPLES = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // echo_time[15:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // calibrated_distance[20:0], linear_measure[41:21], plate_count[61:42], zeros
   output logic [63:0]                       rsp_tdata,
   input  logic                              csr_we,
   input  logic [uea_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [uea_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CountW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SW     = uea_pkg::SUM_W;
   localparam int NW     = uea_pkg::DIV_N_W;

   uea_pkg::state_type state_ff, state_in;

   logic [uea_pkg::CFG_W-1:0]   ref_ff, thick_ff;
   logic [SW-1:0]               sum_ff, sum_in;
   logic [CountW-1:0]           cnt_ff, cnt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [uea_pkg::DIST_W-1:0]  rsp_dist_ff, rsp_lin_ff;
   logic [uea_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        accept, last, load;
   logic [SW-1:0]               sum_add;
   logic [CountW:0]             cnt_next;

   logic                        div_start;
   logic [NW-1:0]               div_dividend;
   logic [uea_pkg::DIV_D_W-1:0] div_divisor;
   uea_pkg::div_status_type     div_status;
   logic [NW-1:0]               div_quotient;

   logic                        cal_start, cal_valid;
   logic [uea_pkg::DIST_W-1:0]  cal_dist, cal_lin;

   // shared serial divider
   uea_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // scale and range calibration
   uea_scale_cal u_cal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cal_start),
      .avg       (div_quotient[uea_pkg::ECHO_W-1:0]),
      .ref_dist  (ref_ff),
      .out_valid (cal_valid),
      .distance  (cal_dist),
      .lin       (cal_lin)
   );

   // accumulation datapath
   always_comb begin
      accept   = req_tvalid & req_tready;
      sum_add  = sum_ff + SW'(req_tdata);
      cnt_next = {1'b0, cnt_ff} + 1'b1;
      last     = (cnt_next >= (CountW + 1)'(SAMPLES));
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      if (accept) begin
         sum_in = last ? '0 : sum_add;
         cnt_in = last ? '0 : cnt_next[CountW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_dividend = NW'(sum_add);
      div_divisor  = uea_pkg::DIV_D_W'(SAMPLES);
      cal_start    = 1'b0;
      load         = 1'b0;
      case (state_ff)
         uea_pkg::ST_ACCUM: begin
            req_tready = 1'b1;
            if (accept && last) begin
               div_start = 1'b1;
               state_in  = uea_pkg::ST_AVERAGE;
            end
         end
         uea_pkg::ST_AVERAGE: begin
            if (div_status.done) begin
               cal_start = 1'b1;
               state_in  = uea_pkg::ST_SCALE;
            end
         end
         uea_pkg::ST_SCALE: begin
            div_dividend = {cal_lin, uea_pkg::FRAC_W'(0)};
            div_divisor  = thick_ff;
            if (cal_valid) begin
               div_start = 1'b1;
               state_in  = uea_pkg::ST_COUNT;
            end
         end
         uea_pkg::ST_COUNT: begin
            if (div_status.done) state_in = uea_pkg::ST_HOLD;
         end
         uea_pkg::ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load     = 1'b1;
               state_in = uea_pkg::ST_ACCUM;
            end
         end
         default: state_in = uea_pkg::ST_ACCUM;
      endcase
   end

   // output register, count saturates at 20 bits
   always_comb begin
      if (div_quotient[NW-1:uea_pkg::COUNT_W] != '0) rsp_count_in = '1;
      else rsp_count_in = div_quotient[uea_pkg::COUNT_W-1:0];
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_dist_ff  <= cal_dist;
         rsp_lin_ff   <= cal_lin;
         rsp_count_ff <= rsp_count_in;
      end
      if (reset) begin
         state_ff     <= uea_pkg::ST_ACCUM;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ref_ff       <= '0;
         thick_ff     <= uea_pkg::THICKNESS_RESET;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == uea_pkg::REG_REFERENCE) ref_ff <= csr_wdata;
         if (csr_we && csr_index == uea_pkg::REG_THICKNESS) thick_ff <= csr_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_lin_ff, rsp_dist_ff};

   // checks
   `UEA_ASSERT_IMP(a_start_idle, div_start, !div_status.busy)
   `UEA_ASSERT_IMP(a_accum_div_idle, state_ff == uea_pkg::ST_ACCUM, !div_status.busy)
   `UEA_ASSERT_IMP(a_cnt_range, 1'b1, {1'b0, cnt_ff} < (CountW + 1)'(SAMPLES))
   `UEA_ASSERT_NXT(a_load_valid, load, rsp_tvalid)

endmodule

// ----- rtl/core/uea_serial_div.sv -----
// ----------------------------------------------------------------------------
// uea_serial_div
// Restoring divider, one quotient bit per cycle, quotient held after done.
// ----------------------------------------------------------------------------
module uea_serial_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [uea_pkg::DIV_N_W-1:0]       dividend,
   input  logic [uea_pkg::DIV_D_W-1:0]       divisor,
   output uea_pkg::div_status_type           status,
   output logic [uea_pkg::DIV_N_W-1:0]       quotient
);

   localparam int N = uea_pkg::DIV_N_W;
   localparam int D = uea_pkg::DIV_D_W;

   logic [N-1:0]                    quo_ff, quo_in;
   logic [D-1:0]                    rem_ff, rem_in;
   logic [D-1:0]                    dsr_ff, dsr_in;
   logic [uea_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [D:0]   trial;
   logic [D+1:0] diff;
   logic         ge;

   // trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[N-1]};
      diff  = {1'b0, trial} - {2'b00, dsr_ff};
      ge    = ~diff[D+1];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? diff[D-1:0] : trial[D-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == uea_pkg::DIV_CNT_W'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- rtl/core/uea_scale_cal.sv -----
// ----------------------------------------------------------------------------
// uea_scale_cal
// Scales the average echo time to 0.01 mm, applies the range ladder and
// forms the clamped linear measure. Three register stages.
// ----------------------------------------------------------------------------
module uea_scale_cal (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [uea_pkg::ECHO_W-1:0]    avg,
   input  logic [uea_pkg::CFG_W-1:0]     ref_dist,
   output logic                          out_valid,
   output logic [uea_pkg::DIST_W-1:0]    distance,
   output logic [uea_pkg::DIST_W-1:0]    lin
);

   localparam int W = uea_pkg::DIST_W;

   logic [W-1:0] raw_ff, raw_in;
   logic [W-1:0] dist_ff, dist_in;
   logic [W-1:0] lin_ff, lin_in;
   logic         s1_ff, s2_ff, s3_ff;

   logic [uea_pkg::PROD_W-1:0] prod;

   // stage 1: scale multiply
   always_comb begin
      prod   = uea_pkg::PROD_W'(avg) * uea_pkg::PROD_W'(uea_pkg::SCALE_MUL);
      raw_in = W'(prod >> uea_pkg::SCALE_SHIFT);
   end

   // stage 2: range ladder
   always_comb begin
      if (raw_ff < uea_pkg::RANGE_1)      dist_in = raw_ff;
      else if (raw_ff < uea_pkg::RANGE_2) dist_in = raw_ff - uea_pkg::OFS_SUB_2;
      else if (raw_ff < uea_pkg::RANGE_3) dist_in = raw_ff - uea_pkg::OFS_SUB_3;
      else if (raw_ff < uea_pkg::RANGE_4) dist_in = raw_ff - uea_pkg::OFS_SUB_4;
      else if (raw_ff < uea_pkg::RANGE_5) dist_in = raw_ff + uea_pkg::OFS_ADD_5;
      else if (raw_ff < uea_pkg::RANGE_6) dist_in = raw_ff + uea_pkg::OFS_ADD_6;
      else                                dist_in = raw_ff + uea_pkg::OFS_ADD_7;
   end

   // stage 3: reference minus distance, clamped at zero
   always_comb begin
      lin_in = (ref_dist > dist_ff) ? (ref_dist - dist_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (in_valid) raw_ff <= raw_in;
      if (s1_ff) dist_ff <= dist_in;
      if (s2_ff) lin_ff <= lin_in;
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else begin
         s1_ff <= in_valid;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   assign out_valid = s3_ff;
   assign distance  = dist_ff;
   assign lin       = lin_ff;

endmodule
